// File: sv/imufp_pkg.sv
// Shared types and constants for the IMU serial frame parser.
// No dependencies; used by every module of the block.
package imufp_pkg;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_ACC   = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   localparam int          FRAME_LEN   = 11;
   localparam int          PAYLOAD_LEN = 8;
   localparam int          POS_W       = 4;
   localparam int          IDX_W       = 3;

   localparam logic [POS_W-1:0] POS_HDR   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_FIRST = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

   typedef enum logic [1:0] {
      KIND_ACC   = 2'd0,
      KIND_GYRO  = 2'd1,
      KIND_ANGLE = 2'd2
   } kind_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [15:0]      word_zero;
      logic [15:0]      word_one;
      logic [15:0]      word_two;
      logic [15:0]      word_three;
   } result_type;

endpackage

// File: sv/imufp_assemble.sv
// Frame assembler: byte position counter, type and payload capture, kind decode.
// Depends on imufp_pkg.
module imufp_assemble (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    rx_byte,
   output imufp_pkg::result_type         result,
   output logic [imufp_pkg::POS_W-1:0]   position
);

   logic [imufp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                  type_ff;
   logic [7:0]                  payload_ff [imufp_pkg::PAYLOAD_LEN];
   logic [imufp_pkg::POS_W-1:0] idx_full;
   logic [imufp_pkg::IDX_W-1:0] idx;
   logic                        is_payload;
   logic                        is_close;

   assign idx_full   = pos_ff - imufp_pkg::POS_FIRST;
   assign idx        = idx_full[imufp_pkg::IDX_W-1:0];
   assign is_payload = (pos_ff >= imufp_pkg::POS_FIRST) && (pos_ff < imufp_pkg::POS_LAST);
   assign is_close   = (pos_ff >= imufp_pkg::POS_LAST);
   assign position   = pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (pos_ff == imufp_pkg::POS_HDR) begin
         if (rx_byte == imufp_pkg::HDR_BYTE) pos_in = imufp_pkg::POS_TYPE;
      end else if (is_close) begin
         pos_in = imufp_pkg::POS_HDR;
      end else begin
         pos_in = pos_ff + imufp_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= imufp_pkg::POS_HDR;
      end else if (step) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && pos_ff == imufp_pkg::POS_TYPE) type_ff <= rx_byte;
      if (step && is_payload) payload_ff[idx] <= rx_byte;
   end

   always_comb begin
      result            = '0;
      result.word_zero  = {payload_ff[1], payload_ff[0]};
      result.word_one   = {payload_ff[3], payload_ff[2]};
      result.word_two   = {payload_ff[5], payload_ff[4]};
      result.word_three = {payload_ff[7], payload_ff[6]};
      case (type_ff)
         imufp_pkg::TYPE_ACC: begin
            result.kind  = imufp_pkg::KIND_ACC;
            result.valid = step && is_close;
         end
         imufp_pkg::TYPE_GYRO: begin
            result.kind  = imufp_pkg::KIND_GYRO;
            result.valid = step && is_close;
         end
         imufp_pkg::TYPE_ANGLE: begin
            result.kind  = imufp_pkg::KIND_ANGLE;
            result.valid = step && is_close;
         end
         default: begin
            result.kind  = imufp_pkg::KIND_ACC;
            result.valid = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/imufp_out.sv
// Result register: holds one finished frame until the downstream side takes it.
// Depends on imufp_pkg.
module imufp_out (
   input  logic                  clock,
   input  logic                  reset,
   input  imufp_pkg::result_type result,
   input  logic                  out_ready,
   output logic                  out_free,
   output logic                  out_valid,
   output imufp_pkg::result_type out_data
);

   logic                  valid_ff, valid_in;
   imufp_pkg::result_type data_ff;

   assign out_free  = !valid_ff || out_ready;
   assign valid_in  = out_free ? result.valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && result.valid) data_ff <= result;
   end

endmodule

// File: sv/imu_serial_frame_parser.sv
// Top level of the IMU serial frame parser: input register, assembler, result register.
// Depends on imufp_pkg, imufp_assemble and imufp_out.
//
//   channel | dir | tdata                      | tuser
//   req_    | in  | [7:0] rx_byte              | -
//   rsp_    | out | word_zero..word_three      | [1:0] frame_kind
//
// One byte a cycle is taken unless stalled; the input register feeds the assembler whenever
// the result register is free; a closing byte's result is captured there.
// Synchronous active-high reset clears the position and both valid flags.
// A stalled result holds the byte pipeline; ready then follows rsp_tready while a byte is held.
module imu_serial_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] word_zero, [31:16] word_one,
                                    // [47:32] word_two, [63:48] word_three
   output logic [1:0]  rsp_tuser    // [1:0] frame_kind
);

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  in_byte_ff;
   logic                        out_free;
   logic                        step;
   logic [imufp_pkg::POS_W-1:0] position;
   imufp_pkg::result_type       result;
   imufp_pkg::result_type       out_data;

   assign step        = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_byte_ff <= req_tdata;
   end

   imufp_assemble u_assemble (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_byte  (in_byte_ff),
      .result   (result),
      .position (position)
   );

   imufp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .out_ready (rsp_tready),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_data  (out_data)
   );

   assign rsp_tdata = {out_data.word_three, out_data.word_two,
                       out_data.word_one, out_data.word_zero};
   assign rsp_tuser = out_data.kind;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      position <= imufp_pkg::POS_LAST)
      else $error("frame position out of range");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("invalid frame kind on result");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a byte while stalled");

   a_emit_close: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> step && position == imufp_pkg::POS_LAST)
      else $error("result raised outside the closing byte");

endmodule
